>>> hdl/aoeu_pkg.sv
// Shared types, constants and rounding helpers for the Adam element update.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package aoeu_pkg;

    localparam int ROW_ID_BITS  = 20;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    localparam logic [31:0] RST_BETA_FIRST  = 32'h3F66_6666;
    localparam logic [31:0] RST_BETA_SECOND = 32'h3F7F_BE77;
    localparam logic [31:0] RST_STEP_SIZE   = 32'h0000_0000;
    localparam logic [31:0] RST_CORR2_ROOT  = 32'h3F80_0000;
    localparam logic [31:0] RST_EPSILON     = 32'h322B_CC77;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BETA_FIRST  = 3'd0,
        CFG_BETA_SECOND = 3'd1,
        CFG_STEP_SIZE   = 3'd2,
        CFG_CORR2_ROOT  = 3'd3,
        CFG_EPSILON     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FC_NUM,
        FC_ZERO,
        FC_INF,
        FC_NAN
    } t_fcls;

    // Unit latencies in pipeline stages.
    localparam int DIV_STEPS  = 26;
    localparam int SQRT_STEPS = 25;
    localparam int LAT_MUL    = 2;
    localparam int LAT_ADD    = 2;
    localparam int LAT_DIV    = DIV_STEPS + 2;
    localparam int LAT_SQRT   = SQRT_STEPS + 2;

    // Stage at which each intermediate value is ready.
    localparam int T_C   = LAT_ADD;
    localparam int T_GM  = T_C + LAT_MUL;
    localparam int T_M   = T_GM + LAT_ADD;
    localparam int T_T   = T_GM + LAT_MUL;
    localparam int T_V   = T_T + LAT_ADD;
    localparam int T_LM  = T_M + LAT_MUL;
    localparam int T_S   = T_V + LAT_SQRT;
    localparam int T_D   = T_S + LAT_DIV;
    localparam int T_DEN = T_D + LAT_ADD;
    localparam int T_U   = T_DEN + LAT_DIV;
    localparam int T_W   = T_U + LAT_ADD;

    localparam int D_MB = T_GM - LAT_MUL;
    localparam int D_VB = T_T - LAT_MUL;
    localparam int D_M  = T_W - T_M;
    localparam int D_V  = T_W - T_V;
    localparam int D_LM = T_DEN - T_LM;

    typedef struct packed {
        logic [31:0]            weight;
        logic [31:0]            moment_first;
        logic [31:0]            moment_second;
        logic [ROW_ID_BITS-1:0] row;
        logic                   write;
    } t_result;

    // Round to nearest even and pack; results below the normal range flush to
    // a signed zero; an all-ones mantissa at exponent zero gives the smallest normal.
    function automatic logic [31:0] fp_round_pack(input logic sgn,
                                                  input logic signed [9:0] ex,
                                                  input logic [23:0] mant,
                                                  input logic guard,
                                                  input logic sticky);
        logic              up;
        logic [24:0]       mr;
        logic signed [9:0] er;
        logic [31:0]       res;
        up = guard & (sticky | mant[0]);
        mr = {1'b0, mant} + {24'd0, up};
        er = ex + $signed({9'd0, mr[24]});
        if (ex == 10'sd0 && (&mant)) begin
            res = {sgn, 8'd1, 23'd0};
        end else if (ex <= 10'sd0) begin
            res = {sgn, 31'd0};
        end else if (er >= 10'sd255) begin
            res = {sgn, 8'hFF, 23'd0};
        end else begin
            res = {sgn, er[7:0], mr[22:0]};
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_select(input t_fcls cls, input logic sgn,
                                              input logic [31:0] num);
        logic [31:0] res;
        case (cls)
            FC_NAN:  res = FP_QNAN;
            FC_INF:  res = {sgn, 8'hFF, 23'd0};
            FC_ZERO: res = {sgn, 31'd0};
            default: res = num;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] fp_canon(input logic [31:0] x);
        logic [31:0] res;
        res = x;
        if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
            res = FP_QNAN;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/adam_optimizer_element_update.sv
// Top level of the Adam element update: configuration registers, the
// arithmetic pipeline and the output skid. Uses aoeu_pkg and the fp units.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one parameter element per
//   item: weight, gradient, both moments, a row id and the opcode.
//   Output channel (o_out_valid / i_out_ready) returns one result item per
//   input item, in order: new weight, new moments, row id and the write flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one of five
//   float registers; it is always ready and should be used while no item is
//   in flight.
//   One item can be accepted every cycle while o_in_ready is high. The delay
//   from acceptance to o_out_valid is set mainly by the two 28-stage dividers
//   and the 27-stage square root on the dependent chain.
//   When the receiver stalls, the pipeline keeps running until the skid
//   register behind the output register fills; then o_in_ready drops and the
//   whole pipeline holds. Synchronous reset empties the pipeline and restores
//   the register defaults; no clearing pass is needed.
`default_nettype none

module adam_optimizer_element_update import aoeu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [31:0]             i_weight_in,
    input  logic [31:0]             i_gradient,
    input  logic [31:0]             i_moment_first_in,
    input  logic [31:0]             i_moment_second_in,
    input  logic [ROW_ID_BITS-1:0]  i_row_index,
    input  logic                    i_opcode,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [31:0]             o_weight_out,
    output logic [31:0]             o_moment_first_out,
    output logic [31:0]             o_moment_second_out,
    output logic [ROW_ID_BITS-1:0]  o_row_echo,
    output logic                    o_moments_write,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    logic [31:0] r_beta_first, r_beta_second, r_step_size, r_corr2_root, r_epsilon;

    logic w_en, w_acc, w_push, w_pop;
    logic [T_W:0] r_vld;

    logic [31:0]            r_wd  [0:T_U];
    logic [31:0]            r_gd  [0:T_GM];
    logic [31:0]            r_m0, r_v0;
    logic [ROW_ID_BITS-1:0] r_row [0:T_W];
    logic                   r_op  [0:T_W];
    logic [31:0]            r_mbd [0:D_MB-1];
    logic [31:0]            r_vbd [0:D_VB-1];
    logic [31:0]            r_md  [0:D_M-1];
    logic [31:0]            r_vd  [0:D_V-1];
    logic [31:0]            r_lmd [0:D_LM-1];

    logic [31:0] w_mb, w_vb, w_c1, w_c2, w_gm, w_gv, w_m, w_t, w_v, w_lm;
    logic [31:0] w_s, w_d, w_den, w_u, w_wn;

    t_result w_res, r_out, r_skd;
    logic    r_out_vld, r_skd_vld;

    assign w_en   = !r_skd_vld;
    assign w_acc  = i_in_valid && w_en;
    assign w_push = w_en && r_vld[T_W];
    assign w_pop  = r_out_vld && i_out_ready;

    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_first  <= RST_BETA_FIRST;
            r_beta_second <= RST_BETA_SECOND;
            r_step_size   <= RST_STEP_SIZE;
            r_corr2_root  <= RST_CORR2_ROOT;
            r_epsilon     <= RST_EPSILON;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BETA_FIRST:  r_beta_first  <= i_cfg_data;
                CFG_BETA_SECOND: r_beta_second <= i_cfg_data;
                CFG_STEP_SIZE:   r_step_size   <= i_cfg_data;
                CFG_CORR2_ROOT:  r_corr2_root  <= i_cfg_data;
                CFG_EPSILON:     r_epsilon     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[T_W-1:0], w_acc};
        end
    end

    // Side values ride along in delay lines matched to the unit latencies.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wd[0]  <= i_weight_in;
            r_gd[0]  <= i_gradient;
            r_m0     <= i_moment_first_in;
            r_v0     <= i_moment_second_in;
            r_row[0] <= i_row_index;
            r_op[0]  <= i_opcode;
            for (int i = 1; i <= T_U; i++) r_wd[i] <= r_wd[i-1];
            for (int i = 1; i <= T_GM; i++) r_gd[i] <= r_gd[i-1];
            for (int i = 1; i <= T_W; i++) begin
                r_row[i] <= r_row[i-1];
                r_op[i]  <= r_op[i-1];
            end
            r_mbd[0] <= w_mb;
            for (int i = 1; i < D_MB; i++) r_mbd[i] <= r_mbd[i-1];
            r_vbd[0] <= w_vb;
            for (int i = 1; i < D_VB; i++) r_vbd[i] <= r_vbd[i-1];
            r_md[0] <= w_m;
            for (int i = 1; i < D_M; i++) r_md[i] <= r_md[i-1];
            r_vd[0] <= w_v;
            for (int i = 1; i < D_V; i++) r_vd[i] <= r_vd[i-1];
            r_lmd[0] <= w_lm;
            for (int i = 1; i < D_LM; i++) r_lmd[i] <= r_lmd[i-1];
        end
    end

    aoeu_fmul u_mul_mb (.i_clk, .i_en(w_en), .i_a(r_beta_first), .i_b(r_m0), .o_y(w_mb));
    aoeu_fmul u_mul_vb (.i_clk, .i_en(w_en), .i_a(r_beta_second), .i_b(r_v0), .o_y(w_vb));
    aoeu_fadd u_add_c1 (.i_clk, .i_en(w_en), .i_a(FP_ONE),
                        .i_b({~r_beta_first[31], r_beta_first[30:0]}), .o_y(w_c1));
    aoeu_fadd u_add_c2 (.i_clk, .i_en(w_en), .i_a(FP_ONE),
                        .i_b({~r_beta_second[31], r_beta_second[30:0]}), .o_y(w_c2));
    aoeu_fmul u_mul_gm (.i_clk, .i_en(w_en), .i_a(w_c1), .i_b(r_gd[T_C]), .o_y(w_gm));
    aoeu_fmul u_mul_gv (.i_clk, .i_en(w_en), .i_a(w_c2), .i_b(r_gd[T_C]), .o_y(w_gv));
    aoeu_fadd u_add_m  (.i_clk, .i_en(w_en), .i_a(r_mbd[D_MB-1]), .i_b(w_gm), .o_y(w_m));
    aoeu_fmul u_mul_t  (.i_clk, .i_en(w_en), .i_a(w_gv), .i_b(r_gd[T_GM]), .o_y(w_t));
    aoeu_fadd u_add_v  (.i_clk, .i_en(w_en), .i_a(r_vbd[D_VB-1]), .i_b(w_t), .o_y(w_v));
    aoeu_fmul u_mul_lm (.i_clk, .i_en(w_en), .i_a(r_step_size), .i_b(w_m), .o_y(w_lm));
    aoeu_fsqrt u_sqrt  (.i_clk, .i_en(w_en), .i_a(w_v), .o_y(w_s));
    aoeu_fdiv u_div_d  (.i_clk, .i_en(w_en), .i_a(w_s), .i_b(r_corr2_root), .o_y(w_d));
    aoeu_fadd u_add_de (.i_clk, .i_en(w_en), .i_a(w_d), .i_b(r_epsilon), .o_y(w_den));
    aoeu_fdiv u_div_u  (.i_clk, .i_en(w_en), .i_a(r_lmd[D_LM-1]), .i_b(w_den), .o_y(w_u));
    aoeu_fadd u_add_w  (.i_clk, .i_en(w_en), .i_a(r_wd[T_U]),
                        .i_b({~w_u[31], w_u[30:0]}), .o_y(w_wn));

    always_comb begin
        w_res.weight        = fp_canon(w_wn);
        w_res.moment_first  = fp_canon(r_md[D_M-1]);
        w_res.moment_second = fp_canon(r_vd[D_V-1]);
        w_res.row           = r_row[T_W];
        w_res.write         = r_op[T_W];
    end

    // Output register with one skid entry; the pipeline holds only when the
    // skid entry is occupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (w_pop) begin
            if (r_skd_vld) begin
                r_out     <= r_skd;
                r_skd_vld <= 1'b0;
            end else if (w_push) begin
                r_out <= w_res;
            end else begin
                r_out_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skd     <= w_res;
                r_skd_vld <= 1'b1;
            end
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_weight_out        = r_out.weight;
    assign o_moment_first_out  = r_out.moment_first;
    assign o_moment_second_out = r_out.moment_second;
    assign o_row_echo          = r_out.row;
    assign o_moments_write     = r_out.write;

endmodule

`default_nettype wire

>>> hdl/aoeu_fmul.sv
// Two-stage single-precision multiplier with flush-to-zero.
// Depends on aoeu_pkg for classes and rounding.
`default_nettype none

module aoeu_fmul import aoeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic [7:0]        ea, eb;
    logic              za, zb, ia, ib, na, nb;
    t_fcls             n_cls, r_cls;
    logic              n_sgn, r_sgn;
    logic [47:0]       n_prod, r_prod;
    logic signed [9:0] n_ex, r_ex;
    logic [23:0]       mant;
    logic              guard, sticky;
    logic signed [9:0] ex2;
    logic [31:0]       n_y, r_y;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        za = (ea == 8'd0);
        zb = (eb == 8'd0);
        ia = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        ib = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        na = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        nb = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        n_sgn = i_a[31] ^ i_b[31];
        if (na || nb || (ia && zb) || (ib && za)) begin
            n_cls = FC_NAN;
        end else if (ia || ib) begin
            n_cls = FC_INF;
        end else if (za || zb) begin
            n_cls = FC_ZERO;
        end else begin
            n_cls = FC_NUM;
        end
        n_prod = {24'd0, 1'b1, i_a[22:0]} * {24'd0, 1'b1, i_b[22:0]};
        n_ex   = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
    end

    always_comb begin
        if (r_prod[47]) begin
            mant   = r_prod[47:24];
            guard  = r_prod[23];
            sticky = |r_prod[22:0];
            ex2    = r_ex + 10'sd1;
        end else begin
            mant   = r_prod[46:23];
            guard  = r_prod[22];
            sticky = |r_prod[21:0];
            ex2    = r_ex;
        end
        n_y = fp_select(r_cls, r_sgn, fp_round_pack(r_sgn, ex2, mant, guard, sticky));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cls  <= n_cls;
            r_sgn  <= n_sgn;
            r_prod <= n_prod;
            r_ex   <= n_ex;
            r_y    <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

>>> hdl/aoeu_fadd.sv
// Two-stage single-precision adder: align and add, then normalize and round.
// Depends on aoeu_pkg for classes and rounding.
`default_nettype none

module aoeu_fadd import aoeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic [7:0]  ea, eb, ebig, esml;
    logic        za, zb, ia, ib, na, nb;
    logic [30:0] mag_a, mag_b;
    logic        a_big;
    logic [23:0] mbig, msml;
    logic [7:0]  dexp;
    logic [4:0]  dcap;
    logic [53:0] wide;
    logic [26:0] abig, asml;
    t_fcls       n_cls, r_cls;
    logic        n_infs, r_infs;
    logic        n_zs, r_zs;
    logic        n_sgn, r_sgn;
    logic [27:0] n_sum, r_sum;
    logic [7:0]  n_ex, r_ex;
    logic [4:0]  lz;
    logic [26:0] sh;
    logic [23:0] mant;
    logic        guard, sticky;
    logic signed [9:0] ex2;
    logic [31:0] n_y, r_y;

    function automatic logic [4:0] lzc27(input logic [26:0] x);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (x[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        za = (ea == 8'd0);
        zb = (eb == 8'd0);
        ia = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        ib = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        na = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        nb = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        mag_a = za ? 31'd0 : i_a[30:0];
        mag_b = zb ? 31'd0 : i_b[30:0];
        a_big = (mag_a >= mag_b);
        ebig  = a_big ? mag_a[30:23] : mag_b[30:23];
        esml  = a_big ? mag_b[30:23] : mag_a[30:23];
        mbig  = a_big ? {~za, mag_a[22:0]} : {~zb, mag_b[22:0]};
        msml  = a_big ? {~zb, mag_b[22:0]} : {~za, mag_a[22:0]};
        n_sgn = a_big ? i_a[31] : i_b[31];
        dexp  = ebig - esml;
        dcap  = (dexp > 8'd26) ? 5'd27 : dexp[4:0];
        // The smaller operand keeps guard, round and sticky bits below its lsb.
        wide  = {msml, 30'd0} >> dcap;
        abig  = {mbig, 3'b000};
        asml  = {wide[53:28], wide[27] | (|wide[26:0])};
        if (i_a[31] ^ i_b[31]) begin
            n_sum = {1'b0, abig} - {1'b0, asml};
        end else begin
            n_sum = {1'b0, abig} + {1'b0, asml};
        end
        n_ex   = ebig;
        n_zs   = i_a[31] & i_b[31];
        n_infs = ia ? i_a[31] : i_b[31];
        if (na || nb || (ia && ib && (i_a[31] != i_b[31]))) begin
            n_cls = FC_NAN;
        end else if (ia || ib) begin
            n_cls = FC_INF;
        end else begin
            n_cls = FC_NUM;
        end
    end

    always_comb begin
        lz = lzc27(r_sum[26:0]);
        sh = r_sum[26:0] << lz;
        if (r_sum[27]) begin
            mant   = r_sum[27:4];
            guard  = r_sum[3];
            sticky = |r_sum[2:0];
            ex2    = $signed({2'b00, r_ex}) + 10'sd1;
        end else begin
            mant   = sh[26:3];
            guard  = sh[2];
            sticky = |sh[1:0];
            ex2    = $signed({2'b00, r_ex}) - $signed({5'd0, lz});
        end
        // An exact zero sum is negative only when both operands were negative.
        if (r_cls == FC_NUM && r_sum == 28'd0) begin
            n_y = {r_zs, 31'd0};
        end else begin
            n_y = fp_select(r_cls, r_infs, fp_round_pack(r_sgn, ex2, mant, guard, sticky));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cls  <= n_cls;
            r_infs <= n_infs;
            r_zs   <= n_zs;
            r_sgn  <= n_sgn;
            r_sum  <= n_sum;
            r_ex   <= n_ex;
            r_y    <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

>>> hdl/aoeu_fdiv.sv
// Pipelined single-precision divider, one restoring quotient bit per stage.
// Depends on aoeu_pkg for classes, step count and rounding.
`default_nettype none

module aoeu_fdiv import aoeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic [7:0]        ea, eb;
    logic              za, zb, ia, ib, na, nb;
    t_fcls             n_cls0;
    logic signed [9:0] n_ex0;

    logic [24:0]          r_rem [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q   [0:DIV_STEPS];
    logic [23:0]          r_dvs [0:DIV_STEPS];
    t_fcls                r_cls [0:DIV_STEPS];
    logic                 r_sgn [0:DIV_STEPS];
    logic signed [9:0]    r_ex  [0:DIV_STEPS];

    logic [24:0]          n_rem [1:DIV_STEPS];
    logic [DIV_STEPS-1:0] n_q   [1:DIV_STEPS];

    logic [23:0]       mant;
    logic              guard, sticky;
    logic signed [9:0] ex2;
    logic [31:0]       n_y, r_y;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        za = (ea == 8'd0);
        zb = (eb == 8'd0);
        ia = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        ib = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        na = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        nb = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        if (na || nb || (za && zb) || (ia && ib)) begin
            n_cls0 = FC_NAN;
        end else if (ia || zb) begin
            n_cls0 = FC_INF;
        end else if (za || ib) begin
            n_cls0 = FC_ZERO;
        end else begin
            n_cls0 = FC_NUM;
        end
        n_ex0 = $signed({2'b00, ea}) - $signed({2'b00, eb}) + 10'sd127;
    end

    always_comb begin
        for (int i = 1; i <= DIV_STEPS; i++) begin
            if (r_rem[i-1] >= {1'b0, r_dvs[i-1]}) begin
                n_rem[i] = (r_rem[i-1] - {1'b0, r_dvs[i-1]}) << 1;
                n_q[i]   = {r_q[i-1][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[i] = r_rem[i-1] << 1;
                n_q[i]   = {r_q[i-1][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    // The top quotient bit has weight one; a quotient below one takes one
    // more bit from the bottom and one less from the exponent.
    always_comb begin
        if (r_q[DIV_STEPS][DIV_STEPS-1]) begin
            mant   = r_q[DIV_STEPS][DIV_STEPS-1:DIV_STEPS-24];
            guard  = r_q[DIV_STEPS][DIV_STEPS-25];
            sticky = r_q[DIV_STEPS][0] | (r_rem[DIV_STEPS] != 25'd0);
            ex2    = r_ex[DIV_STEPS];
        end else begin
            mant   = r_q[DIV_STEPS][DIV_STEPS-2:DIV_STEPS-25];
            guard  = r_q[DIV_STEPS][0];
            sticky = (r_rem[DIV_STEPS] != 25'd0);
            ex2    = r_ex[DIV_STEPS] - 10'sd1;
        end
        n_y = fp_select(r_cls[DIV_STEPS], r_sgn[DIV_STEPS],
                        fp_round_pack(r_sgn[DIV_STEPS], ex2, mant, guard, sticky));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {2'b01, i_a[22:0]};
            r_q[0]   <= '0;
            r_dvs[0] <= {1'b1, i_b[22:0]};
            r_cls[0] <= n_cls0;
            r_sgn[0] <= i_a[31] ^ i_b[31];
            r_ex[0]  <= n_ex0;
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_rem[i] <= n_rem[i];
                r_q[i]   <= n_q[i];
                r_dvs[i] <= r_dvs[i-1];
                r_cls[i] <= r_cls[i-1];
                r_sgn[i] <= r_sgn[i-1];
                r_ex[i]  <= r_ex[i-1];
            end
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

>>> hdl/aoeu_fsqrt.sv
// Pipelined single-precision square root, one root bit per stage.
// Depends on aoeu_pkg for classes, step count and rounding.
`default_nettype none

module aoeu_fsqrt import aoeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    output logic [31:0] o_y
);

    logic [7:0]  ea;
    t_fcls       n_cls0;
    logic [24:0] mant2;
    logic [8:0]  n_ex0;

    logic [49:0]           r_rad  [0:SQRT_STEPS];
    logic [25:0]           r_rem  [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_root [0:SQRT_STEPS];
    t_fcls                 r_cls  [0:SQRT_STEPS];
    logic                  r_sgn  [0:SQRT_STEPS];
    logic [8:0]            r_ex   [0:SQRT_STEPS];

    logic [27:0]           cur    [1:SQRT_STEPS];
    logic [27:0]           trial  [1:SQRT_STEPS];
    logic [25:0]           n_rem  [1:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] n_root [1:SQRT_STEPS];

    logic [31:0] n_y, r_y;

    always_comb begin
        ea = i_a[30:23];
        if (ea == 8'hFF && i_a[22:0] != 23'd0) begin
            n_cls0 = FC_NAN;
        end else if (ea == 8'd0) begin
            n_cls0 = FC_ZERO;
        end else if (i_a[31]) begin
            n_cls0 = FC_NAN;
        end else if (ea == 8'hFF) begin
            n_cls0 = FC_INF;
        end else begin
            n_cls0 = FC_NUM;
        end
        // An even biased exponent means an odd true exponent: double the mantissa.
        mant2 = ea[0] ? {2'b01, i_a[22:0]} : {1'b1, i_a[22:0], 1'b0};
        n_ex0 = 9'(({1'b0, ea} + 9'd126 + {8'd0, ea[0]}) >> 1);
    end

    always_comb begin
        for (int i = 1; i <= SQRT_STEPS; i++) begin
            cur[i]   = {r_rem[i-1], r_rad[i-1][49:48]};
            trial[i] = {1'b0, r_root[i-1], 2'b01};
            if (cur[i] >= trial[i]) begin
                n_rem[i]  = 26'(cur[i] - trial[i]);
                n_root[i] = {r_root[i-1][SQRT_STEPS-2:0], 1'b1};
            end else begin
                n_rem[i]  = cur[i][25:0];
                n_root[i] = {r_root[i-1][SQRT_STEPS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_y = fp_select(r_cls[SQRT_STEPS], r_sgn[SQRT_STEPS],
                        fp_round_pack(1'b0, $signed({1'b0, r_ex[SQRT_STEPS]}),
                                      r_root[SQRT_STEPS][SQRT_STEPS-1:1],
                                      r_root[SQRT_STEPS][0],
                                      r_rem[SQRT_STEPS] != 26'd0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= {mant2, 25'd0};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_cls[0]  <= n_cls0;
            r_sgn[0]  <= i_a[31];
            r_ex[0]   <= n_ex0;
            for (int i = 1; i <= SQRT_STEPS; i++) begin
                r_rad[i]  <= {r_rad[i-1][47:0], 2'b00};
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_cls[i]  <= r_cls[i-1];
                r_sgn[i]  <= r_sgn[i-1];
                r_ex[i]   <= r_ex[i-1];
            end
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

>>> hdl/aoeu_checker.sv
// Port-level checks for the Adam element update, bound to the top level.
// Depends on aoeu_pkg for the row width and the quiet NaN pattern.
`default_nettype none

module aoeu_checker import aoeu_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [31:0]             o_weight_out,
    input logic [31:0]             o_moment_second_out,
    input logic [ROW_ID_BITS-1:0]  o_row_echo,
    input logic                    o_moments_write
);

    // A stalled result item keeps its weight, row id and write flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_weight_out)
            && $stable(o_row_echo) && $stable(o_moments_write))
        else $error("stalled result item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // Input back-pressure only comes from a full output stage.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result item waiting");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !i_out_ready |=> !o_in_ready)
        else $error("stall released without the output being taken");

    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_moment_second_out[30:23] == 8'hFF)
            && (o_moment_second_out[22:0] != 23'd0) |-> o_moment_second_out == FP_QNAN)
        else $error("non-canonical NaN on output");

endmodule

bind adam_optimizer_element_update aoeu_checker u_aoeu_checker (.*);

`default_nettype wire
